FILE: hw/rtl/md4_pkg.sv
package md4_pkg;

  // Initial chaining vector
  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hEFCD_AB89;
  localparam logic [31:0] IV_C = 32'h98BA_DCFE;
  localparam logic [31:0] IV_D = 32'h1032_5476;

  // Round additive constants
  localparam logic [31:0] K_G = 32'h5A82_7999;
  localparam logic [31:0] K_H = 32'h6ED9_EBA1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 48;
  localparam int unsigned WORD_AW     = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W     = $clog2(ROUNDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_DONE
  } md4_state_e;

  // Source of the block being compressed
  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_PAD1,
    MODE_PAD2
  } md4_mode_e;

  // Message word index for a round
  function automatic logic [WORD_AW-1:0] word_index(input logic [ROUND_W-1:0] rnd);
    logic [3:0] j;
    logic [WORD_AW-1:0] idx;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = j;
      2'd1:    idx = {j[1:0], j[3:2]};
      2'd2:    idx = {j[0], j[1], j[2], j[3]};
      default: idx = j;
    endcase
    return idx;
  endfunction

  // Left rotate amount for a round
  function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'b00_00: s = 5'd3;
      4'b00_01: s = 5'd7;
      4'b00_10: s = 5'd11;
      4'b00_11: s = 5'd19;
      4'b01_00: s = 5'd3;
      4'b01_01: s = 5'd5;
      4'b01_10: s = 5'd9;
      4'b01_11: s = 5'd13;
      4'b10_00: s = 5'd3;
      4'b10_01: s = 5'd9;
      4'b10_10: s = 5'd11;
      4'b10_11: s = 5'd15;
      default:  s = 5'd3;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    return w[63:32];
  endfunction

endpackage

FILE: hw/rtl/md4_hash_engine_top.sv
// MD4 hash engine: one 32-bit message word per request, digest out on the last word.
// Non-last words are buffered; the word that fills a block starts 48 rounds on the
// shared round unit and then a chaining update.
// After the last word one padded block is compressed, or two when the padding spills over.
// Input is not ready while a block is compressed or a finished digest waits for the output register.
// Reset (async, active low) loads the initial vector and clears length, position and valid.
module md4_hash_engine_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // [31:0] message_word, [34:32] byte_count, rest 0
  input  logic         s_axis_tlast,   // last_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_word0, digest_word1, digest_word2, digest_word3
);
  import md4_pkg::*;

  md4_state_e state_q, state_d;
  md4_mode_e  mode_q, mode_d;

  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] buf_mem [BLOCK_WORDS];
  logic [31:0] buf_rd_q;
  logic [WORD_AW-1:0] pos_q, pos_d;
  logic [63:0] bits_q, bits_d;
  logic [ROUND_W-1:0] rnd_q, rnd_d;
  logic [31:0] tail_q, tail_d;
  logic        full_q, full_d;   // last word carried four bytes
  logic        two_q, two_d;     // padding spills into a second block
  logic        out_valid_q, out_valid_d;
  logic [127:0] out_data_q, out_data_d;

  logic        in_acc;
  logic [31:0] in_word;
  logic [2:0]  in_cnt, cnt;
  logic        buf_we;
  logic [6:0]  fill;

  logic [WORD_AW-1:0] k;
  logic [31:0] x, fval, tconst, sum;
  logic [WORD_AW:0] pos_next;

  assign in_word = s_axis_tdata[31:0];
  assign in_cnt  = s_axis_tdata[34:32];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Clamped byte count and padding fill level
  assign cnt  = (in_cnt > 3'd4) ? 3'd4 : in_cnt;
  assign fill = {1'b0, pos_q, 2'b00} + {4'd0, cnt};

  // Message word feeding the current round
  assign k        = word_index(rnd_q);
  assign pos_next = {1'b0, pos_q} + {{WORD_AW{1'b0}}, 1'b1};
  always_comb begin
    x = '0;
    case (mode_q)
      MODE_DATA: x = buf_rd_q;
      MODE_PAD1: begin
        if (k < pos_q)                                     x = buf_rd_q;
        else if (k == pos_q)                               x = tail_q;
        else if (full_q && ({1'b0, k} == pos_next))        x = {24'd0, PAD_BYTE};
        else if (!two_q && (k == WORD_AW'(14)))            x = bits_q[31:0];
        else if (!two_q && (k == WORD_AW'(15)))            x = bits_q[63:32];
        else                                               x = '0;
      end
      MODE_PAD2: begin
        if (k == WORD_AW'(14))                             x = bits_q[31:0];
        else if (k == WORD_AW'(15))                        x = bits_q[63:32];
        else if (full_q && (k == '0) &&
                 (pos_q == WORD_AW'(BLOCK_WORDS - 1)))     x = {24'd0, PAD_BYTE};
        else                                               x = '0;
      end
      default: x = '0;
    endcase
  end

  // Shared round unit
  always_comb begin
    case (rnd_q[5:4])
      2'd0: begin
        fval   = (b_q & c_q) | (~b_q & d_q);
        tconst = '0;
      end
      2'd1: begin
        fval   = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        tconst = K_G;
      end
      default: begin
        fval   = b_q ^ c_q ^ d_q;
        tconst = K_H;
      end
    endcase
    sum = a_q + fval + x + tconst;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tlast || (pos_q == WORD_AW'(BLOCK_WORDS - 1))))
          state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == ROUND_W'(ROUNDS - 1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (mode_q == MODE_PAD1 && two_q) state_d = ST_ROUND;
        else if (mode_q != MODE_DATA)     state_d = ST_DONE;
        else                              state_d = ST_IDLE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mode_d      = mode_q;
    chain_d     = chain_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    pos_d       = pos_q;
    bits_d      = bits_q;
    rnd_d       = rnd_q;
    tail_d      = tail_q;
    full_d      = full_q;
    two_d       = two_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    buf_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rnd_d = '0;
        a_d = chain_q[0]; b_d = chain_q[1]; c_d = chain_q[2]; d_d = chain_q[3];
        if (in_acc) begin
          if (!s_axis_tlast) begin
            buf_we = 1'b1;
            bits_d = bits_q + 64'd32;
            pos_d  = pos_q + WORD_AW'(1);
            mode_d = MODE_DATA;
          end else begin
            bits_d = bits_q + {58'd0, cnt, 3'b000};
            mode_d = MODE_PAD1;
            full_d = (cnt == 3'd4);
            two_d  = (fill >= 7'd56);
            case (cnt)
              3'd0:    tail_d = {24'd0, PAD_BYTE};
              3'd1:    tail_d = {16'd0, PAD_BYTE, in_word[7:0]};
              3'd2:    tail_d = {8'd0, PAD_BYTE, in_word[15:0]};
              3'd3:    tail_d = {PAD_BYTE, in_word[23:0]};
              default: tail_d = in_word;
            endcase
          end
        end
      end
      ST_ROUND: begin
        a_d   = d_q;
        b_d   = rotl32(sum, rot_amount(rnd_q));
        c_d   = b_q;
        d_d   = c_q;
        rnd_d = rnd_q + ROUND_W'(1);
      end
      ST_UPDATE: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        a_d = chain_d[0]; b_d = chain_d[1]; c_d = chain_d[2]; d_d = chain_d[3];
        rnd_d = '0;
        if (mode_q == MODE_PAD1 && two_q) mode_d = MODE_PAD2;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
          chain_d[0]  = IV_A;
          chain_d[1]  = IV_B;
          chain_d[2]  = IV_C;
          chain_d[3]  = IV_D;
          pos_d       = '0;
          bits_d      = '0;
          mode_d      = MODE_DATA;
        end
      end
      default: ;
    endcase
  end

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_DATA;
      chain_q[0]  <= IV_A;
      chain_q[1]  <= IV_B;
      chain_q[2]  <= IV_C;
      chain_q[3]  <= IV_D;
      pos_q       <= '0;
      bits_q      <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      chain_q     <= chain_d;
      pos_q       <= pos_d;
      bits_q      <= bits_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and payload
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    d_q        <= d_d;
    tail_q     <= tail_d;
    full_q     <= full_d;
    two_q      <= two_d;
    out_data_q <= out_data_d;
  end

  // Block buffer; the word for the next round is registered from the next round index
  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[pos_q] <= in_word;
    buf_rd_q <= buf_mem[word_index(rnd_d)];
  end

endmodule

FILE: tb/tb.sv
module tb;

  // One message word request as it travels on the input stream
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } msg_item_t;

  // Digest word n sits in bits 32n+31:32n, as on the output stream
  typedef logic [3:0][31:0] digest_t;

  localparam digest_t     MD4_IV   = {32'h1032_5476, 32'h98BA_DCFE,
                                      32'hEFCD_AB89, 32'h6745_2301};
  localparam logic [31:0] ROUND2_K = 32'h5A82_7999;
  localparam logic [31:0] ROUND3_K = 32'h6ED9_EBA1;
  localparam logic [3:0][4:0] SHIFT_F = {5'd19, 5'd11, 5'd7, 5'd3};
  localparam logic [3:0][4:0] SHIFT_G = {5'd13, 5'd9, 5'd5, 5'd3};
  localparam logic [3:0][4:0] SHIFT_H = {5'd15, 5'd11, 5'd9, 5'd3};
  localparam int unsigned DRAIN_CYCLES = 128;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;

  // Stimulus and expectations
  msg_item_t   pending_words[$];
  digest_t     expected_digests[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_accepted = 0;
  int unsigned messages_queued = 0;
  int unsigned digests_checked = 0;
  int unsigned error_count = 0;

  // Predicted hash state
  digest_t           chain_words = MD4_IV;
  logic [15:0][31:0] msg_block = '0;
  logic [3:0]        fill_pos = '0;
  logic [63:0]       bit_length = '0;

  md4_hash_engine_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // 48-step compression of one block into the predicted chaining words
  function automatic void compress_block(input logic [15:0][31:0] m);
    digest_t     r;
    logic [31:0] f, k, sum, rot, tmp;
    logic [4:0]  s;
    int unsigned j, idx;
    r = chain_words;
    for (int unsigned i = 0; i < 48; i++) begin
      j = i % 16;
      if (i < 16) begin
        f = (r[1] & r[2]) | (~r[1] & r[3]);
        idx = j;
        s = SHIFT_F[i % 4];
        k = '0;
      end else if (i < 32) begin
        f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]);
        idx = (j % 4) * 4 + j / 4;
        s = SHIFT_G[i % 4];
        k = ROUND2_K;
      end else begin
        f = r[1] ^ r[2] ^ r[3];
        // word order of the third round is the 4-bit reversal
        idx = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
        s = SHIFT_H[i % 4];
        k = ROUND3_K;
      end
      sum = r[0] + f + m[idx] + k;
      rot = (sum << s) | (sum >> (6'd32 - s));
      tmp = r[3];
      r[3] = r[2];
      r[2] = r[1];
      r[1] = rot;
      r[0] = tmp;
    end
    for (int unsigned i = 0; i < 4; i++)
      chain_words[i] = chain_words[i] + r[i];
  endfunction

  // Absorb one accepted word; on the last word pad, finish and return the digest
  function automatic void predict_word(input logic [31:0] word, input logic [2:0] count,
                                       input logic last, output logic produced,
                                       output digest_t dg);
    logic [127:0][7:0] pad;
    logic [15:0][31:0] blk;
    int unsigned       tail, nbytes, nblk, stop, base;
    produced = 1'b0;
    dg = '0;
    if (!last) begin
      msg_block[fill_pos] = word;
      bit_length = bit_length + 64'd32;
      fill_pos = fill_pos + 4'd1;
      if (fill_pos == 4'd0)
        compress_block(msg_block);
    end else begin
      // byte count above four is clamped
      tail = (count > 3'd4) ? 4 : count;
      bit_length = bit_length + 64'(8 * tail);
      pad = '0;
      nbytes = 0;
      for (int unsigned i = 0; i < fill_pos; i++)
        for (int unsigned b = 0; b < 4; b++) begin
          pad[nbytes] = msg_block[i][8*b +: 8];
          nbytes++;
        end
      for (int unsigned b = 0; b < tail; b++) begin
        pad[nbytes] = word[8*b +: 8];
        nbytes++;
      end
      pad[nbytes] = 8'h80;
      nbytes++;
      // no room for the length: a second padding block follows
      nblk = (nbytes + 8 > 64) ? 2 : 1;
      stop = nblk * 64;
      for (int unsigned b = 0; b < 8; b++)
        pad[stop - 8 + b] = bit_length[8*b +: 8];
      for (int unsigned n = 0; n < nblk; n++) begin
        for (int unsigned w = 0; w < 16; w++) begin
          base = n * 64 + w * 4;
          blk[w] = {pad[base + 3], pad[base + 2], pad[base + 1], pad[base]};
        end
        compress_block(blk);
      end
      dg = chain_words;
      produced = 1'b1;
      chain_words = MD4_IV;
      fill_pos = '0;
      bit_length = '0;
    end
  endfunction

  // Input driver: predicts on each accepted request, then offers the next word
  always @(posedge clk) begin : drive_words
    msg_item_t nxt;
    digest_t   dg;
    logic      produced;
    logic      launch;
    if (rst_n) begin
      launch = 1'b0;
      if (s_tvalid && s_tready) begin
        words_accepted++;
        predict_word(s_tdata[31:0], s_tdata[34:32], s_tlast, produced, dg);
        if (produced)
          expected_digests.push_back(dg);
      end
      if ((!s_tvalid || s_tready) && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        s_tdata <= {5'b0, nxt.count, nxt.word};
        s_tlast <= nxt.last;
        launch = 1'b1;
      end
      s_tvalid <= launch || (s_tvalid && !s_tready);
    end
  end

  // Output monitor: random backpressure, compare against the oldest expected digest
  always @(posedge clk) begin : check_digests
    digest_t want;
    digest_t got;
    if (rst_n) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        digests_checked++;
        if (expected_digests.size() == 0) begin
          $error("unexpected digest %h", got);
          error_count++;
        end else begin
          want = expected_digests.pop_front();
          for (int unsigned w = 0; w < 4; w++)
            if (got[w] !== want[w]) begin
              $error("digest_word%0d: expected %h, got %h", w, want[w], got[w]);
              error_count++;
            end
        end
      end
    end
  end

  task automatic push_word(input logic [31:0] word, input logic [2:0] count,
                           input logic last);
    msg_item_t it;
    it.word = word;
    it.count = count;
    it.last = last;
    pending_words.push_back(it);
    if (last)
      messages_queued++;
  endtask

  // One message of n_words words; earlier words carry a random, ignored count
  task automatic queue_message(input int unsigned n_words, input logic [2:0] tail_count);
    int unsigned style;
    logic [31:0] word;
    style = $urandom_range(9);
    for (int unsigned i = 0; i < n_words; i++) begin
      case (style)
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      if (i == n_words - 1)
        push_word(word, tail_count, 1'b1);
      else
        push_word(word, 3'($urandom_range(7)), 1'b0);
    end
  endtask

  // Wait until every request is accepted and every digest is back
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending_words.size() > 0 || s_tvalid || expected_digests.size() > 0);
  endtask

  // Random messages, lengths clustered around block and padding boundaries
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_items);
    int unsigned queued, len, pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(9);
      if (pick < 4)
        len = $urandom_range(1, 12);
      else if (pick < 7)
        len = $urandom_range(13, 18);
      else if (pick == 7)
        len = $urandom_range(29, 34);
      else if (pick == 8)
        len = $urandom_range(19, 28);
      else
        len = $urandom_range(35, 70);
      queue_message(len, 3'($urandom_range(7)));
      queued += len;
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message, clamped counts, every short tail, full final block
    send_idle_pct = 12;
    recv_idle_pct = 47;
    push_word(32'h0000_0000, 3'd0, 1'b1);
    push_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    push_word(32'h0063_6261, 3'd3, 1'b1);
    push_word($urandom, 3'd5, 1'b1);
    push_word($urandom, 3'd6, 1'b1);
    push_word($urandom, 3'd1, 1'b1);
    push_word($urandom, 3'd2, 1'b1);
    push_word($urandom, 3'd4, 1'b1);
    push_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    push_word(32'h0000_0000, 3'd4, 1'b1);
    queue_message(16, 3'd4);
    wait_idle();

    run_phase(12, 47, 610);
    run_phase(47, 12, 610);
    run_phase(0, 0, 610);

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Hashed %0d messages from %0d accepted words, %0d digests compared",
             messages_queued, words_accepted, digests_checked);
    $display("Covered sender-idle, receiver-idle and back-to-back phases with full drains");
    if (error_count == 0)
      $display("PASS md4_hash_engine_top");
    else
      $display("FAIL md4_hash_engine_top");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4000000;
    $display("FAIL md4_hash_engine_top");
    $finish;
  end

endmodule
